// ===== src/rlj_pkg.sv =====
// Shared types and constants of the RTP loss and jitter monitor.
// No dependencies; every other file in src imports this package.
package rlj_pkg;

    localparam int CNT_W     = 32;
    localparam int OUT_W     = 32;
    localparam int SEQ_W     = 16;
    localparam int TIME_W    = 32;
    localparam int JIT_W     = 32;
    localparam int RATE_W    = 17;
    localparam int DIV_STEPS = RATE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef enum logic [1:0] {
        REQ_PRE   = 2'd0,
        REQ_POST  = 2'd1,
        REQ_FRAME = 2'd2,
        REQ_TICK  = 2'd3
    } req_type_t;

    typedef struct packed {
        req_type_t          req_type;
        logic [SEQ_W-1:0]   seq;
        logic [TIME_W-1:0]  rtp_timestamp;
        logic [TIME_W-1:0]  arrival_time;
    } req_t;

    typedef struct packed {
        logic               accepted;
        logic [OUT_W-1:0]   total_received;
        logic [OUT_W-1:0]   total_lost;
        logic [OUT_W-1:0]   total_post_fec;
        logic [OUT_W-1:0]   total_lost_post_fec;
        logic [OUT_W-1:0]   recovered;
        logic [OUT_W-1:0]   frames_decoded;
        logic [RATE_W-1:0]  loss_rate;
        logic [RATE_W-1:0]  post_fec_loss_rate;
        logic [JIT_W-1:0]   jitter_report;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic commit;
        logic div_start;
        logic div_post;
        logic save_pre;
        logic save_post;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

// ===== src/rlj_req_if.sv =====
// Request channel of the RTP loss and jitter monitor: valid/ready plus event fields.
// Depends on rlj_pkg for field widths.
interface rlj_req_if import rlj_pkg::*;;
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] rtp_timestamp;
    logic [TIME_W-1:0] arrival_time;

    modport source (output valid, req_type, seq, rtp_timestamp, arrival_time, input ready);
    modport sink   (input valid, req_type, seq, rtp_timestamp, arrival_time, output ready);
endinterface

// ===== src/rlj_rsp_if.sv =====
// Response channel of the RTP loss and jitter monitor: valid/ready plus statistics snapshot.
// Depends on rlj_pkg for field widths.
interface rlj_rsp_if import rlj_pkg::*;;
    logic              valid;
    logic              ready;
    logic              accepted;
    logic [OUT_W-1:0]  total_received;
    logic [OUT_W-1:0]  total_lost;
    logic [OUT_W-1:0]  total_post_fec;
    logic [OUT_W-1:0]  total_lost_post_fec;
    logic [OUT_W-1:0]  recovered;
    logic [OUT_W-1:0]  frames_decoded;
    logic [RATE_W-1:0] loss_rate;
    logic [RATE_W-1:0] post_fec_loss_rate;
    logic [JIT_W-1:0]  jitter_report;

    modport source (output valid, accepted, total_received, total_lost, total_post_fec,
                     total_lost_post_fec, recovered, frames_decoded, loss_rate,
                     post_fec_loss_rate, jitter_report, input ready);
    modport sink   (input valid, accepted, total_received, total_lost, total_post_fec,
                     total_lost_post_fec, recovered, frames_decoded, loss_rate,
                     post_fec_loss_rate, jitter_report, output ready);
endinterface

// ===== src/rlj_div.sv =====
// Restoring divider for Q1.16 loss fractions: lost * 65536 / (lost + received).
// One quotient bit per cycle; depends on rlj_pkg.
module rlj_div
    import rlj_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [CNT_W-1:0]  lost,
    input  logic [CNT_W-1:0]  rx,
    output logic              done,
    output logic [RATE_W-1:0] quot
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [CNT_W+1:0]     rem_reg;
    logic [CNT_W:0]       den_reg;
    logic [RATE_W-1:0]    quot_reg;

    logic                 ge;
    logic [CNT_W+1:0]     rem_sub;

    assign ge      = rem_reg >= {1'b0, den_reg};
    assign rem_sub = ge ? rem_reg - {1'b0, den_reg} : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {2'b00, lost};
            den_reg  <= {1'b0, lost} + {1'b0, rx};
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= {rem_sub[CNT_W:0], 1'b0};
            quot_reg <= {quot_reg[RATE_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = (den_reg == '0) ? '0 : quot_reg;

endmodule

// ===== src/rlj_datapath.sv =====
// Statistics datapath: sequence tracking, jitter estimator, counters and result register.
// Depends on rlj_pkg and rlj_div; driven by rlj_ctrl through cmd_t/status_t.
module rlj_datapath
    import rlj_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    cmd,
    output status_t status,
    input  req_t    req_word,
    output logic    rsp_valid,
    input  logic    rsp_ready,
    output rsp_t    rsp_word
);

    req_type_t          type_reg;
    logic [SEQ_W-1:0]   seq_reg;
    logic [TIME_W-1:0]  ts_reg;
    logic [TIME_W-1:0]  arr_reg;
    logic [JIT_W-1:0]   mag_reg;

    logic               pre_first_reg,  pre_first_next;
    logic               post_first_reg, post_first_next;
    logic [SEQ_W-1:0]   pre_last_seq_reg,  pre_last_seq_next;
    logic [SEQ_W-1:0]   post_last_seq_reg, post_last_seq_next;
    logic [TIME_W-1:0]  last_media_reg, last_media_next;
    logic [TIME_W-1:0]  last_arr_reg,   last_arr_next;
    logic [JIT_W-1:0]   jitter_reg,     jitter_next;
    logic [CNT_W-1:0]   pre_tot_rx_reg,    pre_tot_rx_next;
    logic [CNT_W-1:0]   pre_tot_lost_reg,  pre_tot_lost_next;
    logic [CNT_W-1:0]   pre_int_rx_reg,    pre_int_rx_next;
    logic [CNT_W-1:0]   pre_int_lost_reg,  pre_int_lost_next;
    logic [CNT_W-1:0]   post_tot_rx_reg,   post_tot_rx_next;
    logic [CNT_W-1:0]   post_tot_lost_reg, post_tot_lost_next;
    logic [CNT_W-1:0]   post_int_rx_reg,   post_int_rx_next;
    logic [CNT_W-1:0]   post_int_lost_reg, post_int_lost_next;
    logic [CNT_W-1:0]   frame_cnt_reg,  frame_cnt_next;
    logic [RATE_W-1:0]  rate_pre_reg;
    logic [RATE_W-1:0]  rate_post_reg;
    logic [JIT_W-1:0]   latched_jit_reg, latched_jit_next;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    logic [TIME_W-1:0]  d_arr;
    logic [TIME_W-1:0]  d_ts;
    logic [TIME_W-1:0]  diff;

    logic               sel_post;
    logic               trk_first;
    logic [SEQ_W-1:0]   trk_last;
    logic [SEQ_W-1:0]   gap;
    logic [SEQ_W-1:0]   gap_m1;
    logic               trk_adv;
    logic               pkt_ok;
    logic [CNT_W-1:0]   lost_add;

    logic [TIME_W:0]    jit_p8;
    logic [JIT_W+1:0]   jit_sum;
    logic [JIT_W-1:0]   jit_sat;

    logic               div_done;
    logic [RATE_W-1:0]  div_quot;

    rlj_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .lost  (cmd.div_post ? post_int_lost_reg : pre_int_lost_reg),
        .rx    (cmd.div_post ? post_int_rx_reg : pre_int_rx_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign d_arr = req_word.arrival_time - last_arr_reg;
    assign d_ts  = req_word.rtp_timestamp - last_media_reg;
    assign diff  = d_arr - d_ts;

    assign sel_post  = (type_reg == REQ_POST);
    assign trk_first = sel_post ? post_first_reg : pre_first_reg;
    assign trk_last  = sel_post ? post_last_seq_reg : pre_last_seq_reg;
    assign gap       = seq_reg - trk_last;
    assign gap_m1    = gap - 1'b1;
    assign trk_adv   = trk_first || ((gap != '0) && !gap[SEQ_W-1]);
    assign pkt_ok    = ((type_reg == REQ_PRE) || (type_reg == REQ_POST)) && trk_adv;
    assign lost_add  = trk_first ? '0 : {{(CNT_W-SEQ_W){1'b0}}, gap_m1};

    assign jit_p8  = {1'b0, jitter_reg} + (TIME_W+1)'(8);
    assign jit_sum = {2'b00, jitter_reg} + {2'b00, mag_reg}
                   - {5'b00000, jit_p8[TIME_W:4]};
    assign jit_sat = (jit_sum[JIT_W+1:JIT_W] != 2'b00) ? '1 : jit_sum[JIT_W-1:0];

    always_comb
    begin
        pre_first_next     = pre_first_reg;
        post_first_next    = post_first_reg;
        pre_last_seq_next  = pre_last_seq_reg;
        post_last_seq_next = post_last_seq_reg;
        last_media_next    = last_media_reg;
        last_arr_next      = last_arr_reg;
        jitter_next        = jitter_reg;
        pre_tot_rx_next    = pre_tot_rx_reg;
        pre_tot_lost_next  = pre_tot_lost_reg;
        pre_int_rx_next    = pre_int_rx_reg;
        pre_int_lost_next  = pre_int_lost_reg;
        post_tot_rx_next   = post_tot_rx_reg;
        post_tot_lost_next = post_tot_lost_reg;
        post_int_rx_next   = post_int_rx_reg;
        post_int_lost_next = post_int_lost_reg;
        frame_cnt_next     = frame_cnt_reg;
        latched_jit_next   = latched_jit_reg;
        case (type_reg)
            REQ_PRE:
            begin
                if (trk_adv)
                begin
                    pre_first_next    = 1'b0;
                    pre_last_seq_next = seq_reg;
                    last_media_next   = ts_reg;
                    last_arr_next     = arr_reg;
                    pre_tot_rx_next   = pre_tot_rx_reg + 1'b1;
                    pre_int_rx_next   = pre_int_rx_reg + 1'b1;
                    pre_tot_lost_next = pre_tot_lost_reg + lost_add;
                    pre_int_lost_next = pre_int_lost_reg + lost_add;
                    if (!trk_first)
                    begin
                        jitter_next = jit_sat;
                    end
                end
            end
            REQ_POST:
            begin
                if (trk_adv)
                begin
                    post_first_next    = 1'b0;
                    post_last_seq_next = seq_reg;
                    post_tot_rx_next   = post_tot_rx_reg + 1'b1;
                    post_int_rx_next   = post_int_rx_reg + 1'b1;
                    post_tot_lost_next = post_tot_lost_reg + lost_add;
                    post_int_lost_next = post_int_lost_reg + lost_add;
                end
            end
            REQ_FRAME:
            begin
                frame_cnt_next = frame_cnt_reg + 1'b1;
            end
            REQ_TICK:
            begin
                latched_jit_next   = jitter_reg;
                pre_int_rx_next    = '0;
                pre_int_lost_next  = '0;
                post_int_rx_next   = '0;
                post_int_lost_next = '0;
            end
            default:
            begin
                frame_cnt_next = frame_cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            type_reg <= req_word.req_type;
            seq_reg  <= req_word.seq;
            ts_reg   <= req_word.rtp_timestamp;
            arr_reg  <= req_word.arrival_time;
            mag_reg  <= diff[TIME_W-1] ? (~diff + 1'b1) : diff;
        end
        if (cmd.commit)
        begin
            rsp_reg.accepted            <= pkt_ok;
            rsp_reg.total_received      <= pre_tot_rx_next[OUT_W-1:0];
            rsp_reg.total_lost          <= pre_tot_lost_next[OUT_W-1:0];
            rsp_reg.total_post_fec      <= post_tot_rx_next[OUT_W-1:0];
            rsp_reg.total_lost_post_fec <= post_tot_lost_next[OUT_W-1:0];
            rsp_reg.recovered           <= (pre_tot_lost_next > post_tot_lost_next)
                ? OUT_W'(pre_tot_lost_next - post_tot_lost_next) : '0;
            rsp_reg.frames_decoded      <= frame_cnt_next[OUT_W-1:0];
            rsp_reg.loss_rate           <= rate_pre_reg;
            rsp_reg.post_fec_loss_rate  <= rate_post_reg;
            rsp_reg.jitter_report       <= latched_jit_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_first_reg     <= 1'b1;
            post_first_reg    <= 1'b1;
            pre_last_seq_reg  <= '0;
            post_last_seq_reg <= '0;
            last_media_reg    <= '0;
            last_arr_reg      <= '0;
            jitter_reg        <= '0;
            pre_tot_rx_reg    <= '0;
            pre_tot_lost_reg  <= '0;
            pre_int_rx_reg    <= '0;
            pre_int_lost_reg  <= '0;
            post_tot_rx_reg   <= '0;
            post_tot_lost_reg <= '0;
            post_int_rx_reg   <= '0;
            post_int_lost_reg <= '0;
            frame_cnt_reg     <= '0;
            rate_pre_reg      <= '0;
            rate_post_reg     <= '0;
            latched_jit_reg   <= '0;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.save_pre)
            begin
                rate_pre_reg <= div_quot;
            end
            if (cmd.save_post)
            begin
                rate_post_reg <= div_quot;
            end
            if (cmd.commit)
            begin
                pre_first_reg     <= pre_first_next;
                post_first_reg    <= post_first_next;
                pre_last_seq_reg  <= pre_last_seq_next;
                post_last_seq_reg <= post_last_seq_next;
                last_media_reg    <= last_media_next;
                last_arr_reg      <= last_arr_next;
                jitter_reg        <= jitter_next;
                pre_tot_rx_reg    <= pre_tot_rx_next;
                pre_tot_lost_reg  <= pre_tot_lost_next;
                pre_int_rx_reg    <= pre_int_rx_next;
                pre_int_lost_reg  <= pre_int_lost_next;
                post_tot_rx_reg   <= post_tot_rx_next;
                post_tot_lost_reg <= post_tot_lost_next;
                post_int_rx_reg   <= post_int_rx_next;
                post_int_lost_reg <= post_int_lost_next;
                frame_cnt_reg     <= frame_cnt_next;
                latched_jit_reg   <= latched_jit_next;
                rsp_valid_reg     <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign status.is_tick  = (type_reg == REQ_TICK);
    assign status.div_done = div_done;
    assign status.out_free = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;

    a_tick_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && (type_reg == REQ_TICK)
        |=> (pre_int_rx_reg == '0) && (pre_int_lost_reg == '0)
            && (post_int_rx_reg == '0) && (post_int_lost_reg == '0))
        else $error("interval counters not cleared by report tick");

    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (mag_reg[JIT_W-1] == 1'b0) || (mag_reg[JIT_W-2:0] == '0))
        else $error("jitter magnitude above 2^31");

endmodule

// ===== src/rlj_ctrl.sv =====
// Sequencer of the RTP loss and jitter monitor: capture, divide on tick, commit.
// Depends on rlj_pkg; drives rlj_datapath through cmd_t and reads status_t.
module rlj_ctrl
    import rlj_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_EXEC     = 5'b00010,
        S_DIV_PRE  = 5'b00100,
        S_DIV_POST = 5'b01000,
        S_TICK     = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (status.is_tick)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV_PRE;
                end
                else if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIV_PRE:
            begin
                if (status.div_done)
                begin
                    cmd.save_pre  = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_post  = 1'b1;
                    state_next    = S_DIV_POST;
                end
            end
            S_DIV_POST:
            begin
                if (status.div_done)
                begin
                    cmd.save_post = 1'b1;
                    state_next    = S_TICK;
                end
            end
            S_TICK:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("commit while result register still full");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_EXEC)
        else $error("accepted word not executed next cycle");

    a_div_to_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_POST) && status.div_done |=> state_reg == S_TICK)
        else $error("post-FEC division done without tick commit");

endmodule

// ===== src/rtp_loss_jitter_monitor.sv =====
// Top level of the RTP loss and jitter monitor: joins sequencer and datapath to the channels.
// Depends on rlj_pkg, rlj_req_if, rlj_rsp_if, rlj_ctrl, rlj_datapath.
//
//  channel | dir | word
//  req     | in  | req_type, seq, rtp_timestamp, arrival_time
//  rsp     | out | accepted, totals, recovered, frames_decoded, rates, jitter_report
//
// Packet and frame words are captured (jitter delta), then committed.
// A report tick is captured, then runs two 17-step restoring divisions on one divider,
// pre-FEC then post-FEC, each started and then saved when done, and is then committed.
// One word is in flight at a time; the result register lets the next word be
// captured while the previous result waits. A stalled rsp holds commit.
// Reset is asynchronous, active low, and clears all statistics; no clearing pass.
module rtp_loss_jitter_monitor
    import rlj_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rlj_req_if.sink   req,
    rlj_rsp_if.source rsp
);

    cmd_t    cmd;
    status_t status;
    req_t    req_word;
    rsp_t    rsp_word;

    assign req_word.req_type      = req_type_t'(req.req_type);
    assign req_word.seq           = req.seq;
    assign req_word.rtp_timestamp = req.rtp_timestamp;
    assign req_word.arrival_time  = req.arrival_time;

    rlj_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    rlj_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req_word  (req_word),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp_word  (rsp_word)
    );

    assign rsp.accepted            = rsp_word.accepted;
    assign rsp.total_received      = rsp_word.total_received;
    assign rsp.total_lost          = rsp_word.total_lost;
    assign rsp.total_post_fec      = rsp_word.total_post_fec;
    assign rsp.total_lost_post_fec = rsp_word.total_lost_post_fec;
    assign rsp.recovered           = rsp_word.recovered;
    assign rsp.frames_decoded      = rsp_word.frames_decoded;
    assign rsp.loss_rate           = rsp_word.loss_rate;
    assign rsp.post_fec_loss_rate  = rsp_word.post_fec_loss_rate;
    assign rsp.jitter_report       = rsp_word.jitter_report;

endmodule
